/* rtl/core/sust_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted set table package
// Shared constants, status codes, controller states and the command and
// status structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sust_pkg;

	// Default table size and field widths.
	localparam int SUST_CAPACITY = 32;
	localparam int NUM_W         = 32;
	localparam int VAL_W         = 31;
	localparam int STAT_W        = 3;
	localparam int OUT_TDATA_W   = 40;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_LISTED    = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_DELETED   = 3'd3,
		ST_NOTFOUND  = 3'd4,
		ST_FULL      = 3'd5,
		ST_EMPTY     = 3'd6
	} status_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_DUMP,
		S_SCAN,
		S_INS_RD,
		S_INS_WR,
		S_DEL_RD,
		S_DEL_WR,
		S_EMIT
	} state_t;

	// Table read address selection, relative to the pointer.
	typedef enum logic [2:0] {
		RD_NONE,
		RD_PTR,
		RD_PTR_P1,
		RD_PTR_P2,
		RD_PTR_M1,
		RD_PTR_M2
	} rd_sel_t;

	// Table write data selection; the write address is always the pointer.
	typedef enum logic [1:0] {
		WR_NONE,
		WR_SHIFT,
		WR_VALUE
	} wr_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_CLR,
		PTR_INC,
		PTR_DEC,
		PTR_LOAD_CNT
	} ptr_op_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_DUMP,
		OUT_RESULT
	} out_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load_in;
		ptr_op_t  ptr_op;
		logic     pos_load;
		rd_sel_t  rd_sel;
		wr_sel_t  wr_sel;
		cnt_op_t  cnt_op;
		logic     res_load;
		status_t  res_status;
		out_sel_t out_sel;
	} sust_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op_zero;
		logic op_neg;
		logic op_ovf;
		logic cnt_zero;
		logic cnt_full;
		logic scan_end;
		logic scan_ge;
		logic scan_eq;
		logic ptr_at_pos;
		logic ptr_m1_at_pos;
		logic ptr_last;
		logic ptr_p2_end;
		logic slot_free;
	} sust_stat_t;

endpackage

/* rtl/core/sust_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module sust_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/sust_dp.sv */
// ----------------------------------------------------------------------------
// Sorted set table datapath
// Holds the entry table, the fill count, the scan pointer, the latched
// request and the output register.
// ----------------------------------------------------------------------------
module sust_dp #(
	parameter int CAPACITY = sust_pkg::SUST_CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [sust_pkg::NUM_W-1:0]        s_tdata,
	input  sust_pkg::sust_cmd_t               cmd,
	output sust_pkg::sust_stat_t              stat,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sust_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                              m_tlast
);

	import sust_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PAD_W = OUT_TDATA_W - VAL_W - STAT_W;

	logic [VAL_W-1:0] value_q;
	logic             zero_q;
	logic             neg_q;
	logic             ovf_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    ptr_q;
	logic [CW-1:0]    pos_q;
	status_t          res_status_q;

	logic [NUM_W-1:0] num_mag;
	logic [CW-1:0]    ptr_p1;
	logic [CW-1:0]    ptr_p2;
	logic [CW-1:0]    ptr_m1;
	logic [CW-1:0]    ptr_m2;
	logic [CW-1:0]    raddr_full;
	logic             ram_re;
	logic             ram_we;
	logic [VAL_W-1:0] ram_wdata;
	logic [VAL_W-1:0] ram_rdata;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	status_t          out_status_q;
	logic             out_last_q;

	// Magnitude of a negative request.
	assign num_mag = ~s_tdata + NUM_W'(1);

	// Latched request.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			value_q <= s_tdata[NUM_W-1] ? num_mag[VAL_W-1:0] : s_tdata[VAL_W-1:0];
			zero_q  <= (s_tdata == '0);
			neg_q   <= s_tdata[NUM_W-1];
			ovf_q   <= (s_tdata == {1'b1, {(NUM_W-1){1'b0}}});
		end
		if (cmd.pos_load) begin
			pos_q <= ptr_q;
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
		end
	end

	// Fill count of the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (cmd.cnt_op)
				CNT_HOLD: count_q <= count_q;
				CNT_INC:  count_q <= count_q + CW'(1);
				CNT_DEC:  count_q <= count_q - CW'(1);
				CNT_CLR:  count_q <= '0;
				default:  count_q <= count_q;
			endcase
		end
	end

	// Scan and shift pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else begin
			unique case (cmd.ptr_op)
				PTR_HOLD:     ptr_q <= ptr_q;
				PTR_CLR:      ptr_q <= '0;
				PTR_INC:      ptr_q <= ptr_p1;
				PTR_DEC:      ptr_q <= ptr_m1;
				PTR_LOAD_CNT: ptr_q <= count_q;
				default:      ptr_q <= ptr_q;
			endcase
		end
	end

	assign ptr_p1 = ptr_q + CW'(1);
	assign ptr_p2 = ptr_q + CW'(2);
	assign ptr_m1 = ptr_q - CW'(1);
	assign ptr_m2 = ptr_q - CW'(2);

	// Table read address.
	always_comb begin
		unique case (cmd.rd_sel)
			RD_PTR:    raddr_full = ptr_q;
			RD_PTR_P1: raddr_full = ptr_p1;
			RD_PTR_P2: raddr_full = ptr_p2;
			RD_PTR_M1: raddr_full = ptr_m1;
			RD_PTR_M2: raddr_full = ptr_m2;
			default:   raddr_full = ptr_q;
		endcase
	end

	assign ram_re    = (cmd.rd_sel != RD_NONE);
	assign ram_we    = (cmd.wr_sel != WR_NONE);
	assign ram_wdata = (cmd.wr_sel == WR_SHIFT) ? ram_rdata : value_q;

	sust_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ptr_q[AW-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(raddr_full[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Status toward the controller.
	always_comb begin
		stat.op_zero       = zero_q;
		stat.op_neg        = neg_q;
		stat.op_ovf        = ovf_q;
		stat.cnt_zero      = (count_q == '0);
		stat.cnt_full      = (count_q == CW'(CAPACITY));
		stat.scan_end      = (ptr_q == count_q);
		stat.scan_ge       = (ram_rdata >= value_q);
		stat.scan_eq       = (ram_rdata == value_q);
		stat.ptr_at_pos    = (ptr_q == pos_q);
		stat.ptr_m1_at_pos = (ptr_m1 == pos_q);
		stat.ptr_last      = (ptr_p1 == count_q);
		stat.ptr_p2_end    = (ptr_p2 == count_q);
		stat.slot_free     = !out_valid_q || m_tready;
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_sel != OUT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		unique case (cmd.out_sel)
			OUT_DUMP: begin
				out_value_q  <= ram_rdata;
				out_status_q <= ST_LISTED;
				out_last_q   <= (ptr_p1 == count_q);
			end
			OUT_RESULT: begin
				out_value_q  <= value_q;
				out_status_q <= res_status_q;
				out_last_q   <= 1'b1;
			end
			default: begin
				out_value_q  <= out_value_q;
				out_status_q <= out_status_q;
				out_last_q   <= out_last_q;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_status_q, out_value_q};
	assign m_tlast  = out_last_q;

endmodule

/* rtl/core/sust_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted set table controller
// Sequences the dump, the sorted scan and the shifts of insert and delete.
// ----------------------------------------------------------------------------
module sust_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  sust_pkg::sust_stat_t stat,
	output sust_pkg::sust_cmd_t  cmd
);

	import sust_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   scan_hit;
	logic   scan_match;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// The scan stops at the first entry not below the value.
	assign scan_hit   = stat.scan_end || stat.scan_ge;
	assign scan_match = !stat.scan_end && stat.scan_eq;

	// Next state and commands.
	always_comb begin
		state_nxt      = state_q;
		s_tready       = 1'b0;
		cmd.load_in    = 1'b0;
		cmd.ptr_op     = PTR_HOLD;
		cmd.pos_load   = 1'b0;
		cmd.rd_sel     = RD_NONE;
		cmd.wr_sel     = WR_NONE;
		cmd.cnt_op     = CNT_HOLD;
		cmd.res_load   = 1'b0;
		cmd.res_status = ST_LISTED;
		cmd.out_sel    = OUT_NONE;

		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					cmd.ptr_op  = PTR_CLR;
					state_nxt   = S_DECODE;
				end
			end

			S_DECODE: begin
				if (stat.op_zero) begin
					if (stat.cnt_zero) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_EMPTY;
						state_nxt      = S_EMIT;
					end else begin
						cmd.rd_sel = RD_PTR;
						state_nxt  = S_DUMP;
					end
				end else if (stat.op_ovf) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_NOTFOUND;
					state_nxt      = S_EMIT;
				end else begin
					if (!stat.cnt_zero) begin
						cmd.rd_sel = RD_PTR;
					end
					state_nxt = S_SCAN;
				end
			end

			// One stored entry leaves per cycle while the output side takes it.
			S_DUMP: begin
				if (stat.slot_free) begin
					cmd.out_sel = OUT_DUMP;
					if (stat.ptr_last) begin
						cmd.cnt_op = CNT_CLR;
						state_nxt  = S_IDLE;
					end else begin
						cmd.ptr_op = PTR_INC;
						cmd.rd_sel = RD_PTR_P1;
					end
				end
			end

			S_SCAN: begin
				if (!scan_hit) begin
					cmd.ptr_op = PTR_INC;
					if (!stat.ptr_last) begin
						cmd.rd_sel = RD_PTR_P1;
					end
				end else if (!stat.op_neg) begin
					if (scan_match) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_DUPLICATE;
						state_nxt      = S_EMIT;
					end else if (stat.cnt_full) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_FULL;
						state_nxt      = S_EMIT;
					end else begin
						cmd.pos_load = 1'b1;
						cmd.ptr_op   = PTR_LOAD_CNT;
						state_nxt    = S_INS_RD;
					end
				end else begin
					if (scan_match) begin
						state_nxt = S_DEL_RD;
					end else begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_NOTFOUND;
						state_nxt      = S_EMIT;
					end
				end
			end

			// Insert: move entries up one place from the top down to the slot.
			S_INS_RD: begin
				if (stat.ptr_at_pos) begin
					cmd.wr_sel     = WR_VALUE;
					cmd.cnt_op     = CNT_INC;
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_INSERTED;
					state_nxt      = S_EMIT;
				end else begin
					cmd.rd_sel = RD_PTR_M1;
					state_nxt  = S_INS_WR;
				end
			end

			S_INS_WR: begin
				cmd.wr_sel = WR_SHIFT;
				cmd.ptr_op = PTR_DEC;
				if (stat.ptr_m1_at_pos) begin
					state_nxt = S_INS_RD;
				end else begin
					cmd.rd_sel = RD_PTR_M2;
				end
			end

			// Delete: move entries down one place over the removed slot.
			S_DEL_RD: begin
				if (stat.ptr_last) begin
					cmd.cnt_op     = CNT_DEC;
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_DELETED;
					state_nxt      = S_EMIT;
				end else begin
					cmd.rd_sel = RD_PTR_P1;
					state_nxt  = S_DEL_WR;
				end
			end

			S_DEL_WR: begin
				cmd.wr_sel = WR_SHIFT;
				cmd.ptr_op = PTR_INC;
				if (stat.ptr_p2_end) begin
					state_nxt = S_DEL_RD;
				end else begin
					cmd.rd_sel = RD_PTR_P2;
				end
			end

			S_EMIT: begin
				if (stat.slot_free) begin
					cmd.out_sel = OUT_RESULT;
					state_nxt   = S_IDLE;
				end
			end

			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/sorted_unique_set_table_unit.sv */
// Operation: an insert or delete scans to the slot, then shifts the entries above it by
// one place; a dump reads the entries out in order; result stalls hold up all three.
// Requests: one request at a time; a new request is taken only back in idle, once the
// scan and shift over the entry table for the last one have ended.
// Reset: the fill count is cleared at once; table contents stay undefined and
// need no clearing pass, as only entries below the count are ever read.
// ----------------------------------------------------------------------------
// Sorted unique set table
// Bounded ascending set of positive values with insert, delete and dump.
// ----------------------------------------------------------------------------
module sorted_unique_set_table_unit #(
	parameter int CAPACITY = sust_pkg::SUST_CAPACITY
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [sust_pkg::NUM_W-1:0]       s_tdata,  // [31:0] number
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sust_pkg::OUT_TDATA_W-1:0] m_tdata,  // [30:0] entry_value, [33:31] status
	output logic                             m_tlast
);

	import sust_pkg::*;

	sust_cmd_t  cmd;
	sust_stat_t stat;

	// Controller.
	sust_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Datapath with the entry table and output register.
	sust_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.stat    (stat),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

/* tb/tb_sorted_unique_set_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique set table testbench
// Drives signed numbers into the table and checks every result stream against
// a behavioral copy of the ascending set: inserts, duplicates, full refusals,
// deletes, misses and dumps, under random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_sorted_unique_set_table_unit;
	import sust_pkg::*;

	localparam int TABLE_SIZE = SUST_CAPACITY;

	// One expected result of the table.
	typedef struct {
		logic [VAL_W-1:0] value;
		status_t          status;
		logic             last;
	} set_result_t;

	// Scoreboard: keeps its own copy of the set and the queue of expected results.
	class set_table_scoreboard;
		logic [VAL_W-1:0] stored[$];
		set_result_t      expected[$];
		int               capacity;
		int               errors;

		function new(int cap);
			capacity = cap;
			errors   = 0;
		endfunction

		function void push_result(logic [VAL_W-1:0] value, status_t status, logic last);
			set_result_t r;
			r.value  = value;
			r.status = status;
			r.last   = last;
			expected.push_back(r);
		endfunction

		// Work out the results caused by one accepted request.
		function void note_request(logic [NUM_W-1:0] num);
			logic [NUM_W-1:0] mag;
			int               pos;
			if (num == '0) begin
				if (stored.size() == 0) begin
					push_result('0, ST_EMPTY, 1'b1);
				end else begin
					foreach (stored[i])
						push_result(stored[i], ST_LISTED, i == stored.size() - 1);
					stored.delete();
				end
			end else if (!num[NUM_W-1]) begin
				pos = 0;
				while (pos < stored.size() && stored[pos] < num[VAL_W-1:0])
					pos++;
				if (pos < stored.size() && stored[pos] == num[VAL_W-1:0]) begin
					push_result(num[VAL_W-1:0], ST_DUPLICATE, 1'b1);
				end else if (stored.size() >= capacity) begin
					push_result(num[VAL_W-1:0], ST_FULL, 1'b1);
				end else begin
					stored.insert(pos, num[VAL_W-1:0]);
					push_result(num[VAL_W-1:0], ST_INSERTED, 1'b1);
				end
			end else begin
				mag = -num;
				pos = 0;
				// The most negative number has a magnitude no entry can hold.
				if (mag[NUM_W-1]) begin
					pos = stored.size();
				end else begin
					while (pos < stored.size() && stored[pos] != mag[VAL_W-1:0])
						pos++;
				end
				if (pos >= stored.size()) begin
					push_result(mag[VAL_W-1:0], ST_NOTFOUND, 1'b1);
				end else begin
					stored.delete(pos);
					push_result(mag[VAL_W-1:0], ST_DELETED, 1'b1);
				end
			end
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void check_result(logic [OUT_TDATA_W-1:0] data, logic last);
			set_result_t r;
			if (expected.size() == 0) begin
				$error("unexpected result: tdata 0x%0h tlast %0b", data, last);
				errors++;
				return;
			end
			r = expected.pop_front();
			if (data[VAL_W-1:0] !== r.value) begin
				$error("entry_value: expected %0d, actual %0d", r.value, data[VAL_W-1:0]);
				errors++;
			end
			if (data[VAL_W+STAT_W-1:VAL_W] !== r.status) begin
				$error("status: expected %0d, actual %0d", r.status,
					data[VAL_W+STAT_W-1:VAL_W]);
				errors++;
			end
			if (last !== r.last) begin
				$error("last: expected %0b, actual %0b", r.last, last);
				errors++;
			end
			if (data[OUT_TDATA_W-1:VAL_W+STAT_W] !== '0) begin
				$error("tdata padding: expected 0, actual 0x%0h",
					data[OUT_TDATA_W-1:VAL_W+STAT_W]);
				errors++;
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function int count();
			return stored.size();
		endfunction

		// A value currently in the set, for deletes and duplicates that hit.
		function logic [VAL_W-1:0] pick_stored();
			if (stored.size() == 0)
				return VAL_W'($urandom_range(1, 48));
			return stored[$urandom_range(0, stored.size() - 1)];
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [NUM_W-1:0]       s_tdata;   // [31:0] number
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // [30:0] entry_value, [33:31] status
	logic                   m_tlast;

	set_table_scoreboard sb;
	int                  tx_idle_pct;
	int                  rx_idle_pct;
	int                  rx_hold_req;

	sorted_unique_set_table_unit #(
		.CAPACITY(TABLE_SIZE)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// Clock, 8 ns period.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Overall time limit.
	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off on request.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);
	end

	// Offer one request, optionally after an idle gap, and record it on acceptance.
	task automatic send_request(input logic [NUM_W-1:0] num);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= num;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(num);
	endtask

	// Hold the input quiet until every expected result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// One random request, weighted toward operations that hit the set.
	function automatic logic [NUM_W-1:0] random_request();
		int               r;
		logic [NUM_W-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			v = NUM_W'($urandom_range(1, 48));
		end else if (r < 50) begin
			v = NUM_W'($urandom_range(1, 32'h7FFF_FFFF));
		end else if (r < 68) begin
			v = -{1'b0, sb.pick_stored()};
		end else if (r < 78) begin
			v = -NUM_W'($urandom_range(1, 48));
		end else if (r < 85) begin
			v = -NUM_W'($urandom_range(1, 32'h8000_0000));
		end else if (r < 88) begin
			v = $urandom();
		end else begin
			v = '0;
		end
		return v;
	endfunction

	// Fill the set to capacity, press on it while full, then dump it.
	task automatic fill_and_dump();
		int tries;
		tries = 0;
		while (sb.count() < TABLE_SIZE && tries < 150) begin
			send_request(NUM_W'($urandom_range(1, 200)));
			tries++;
		end
		send_request(NUM_W'($urandom_range(201, 32'h7FFF_FFFF)));
		send_request({1'b0, sb.pick_stored()});
		send_request(-{1'b0, sb.pick_stored()});
		send_request(NUM_W'($urandom_range(201, 400)));
		send_request('0);
	endtask

	task automatic random_phase(input int n_items);
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items / 2)
				fill_and_dump();
			send_request(random_request());
		end
	endtask

	initial begin
		logic [NUM_W-1:0] directed[$];
		sb          = new(TABLE_SIZE);
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		rx_hold_req = 0;
		tx_idle_pct = 37;
		rx_idle_pct = 71;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty dump, field extremes, duplicate, misses, most negative number.
		directed = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001,
			32'h4000_0000, 32'h8000_0001, 32'h8000_0001, 32'h8000_0000,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'h2AAA_AAAA,
			32'h0000_0007, 32'h0000_0003, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0000};
		foreach (directed[i])
			send_request(directed[i]);

		// Sender idles less than the receiver.
		random_phase(70);
		wait_drained();

		// Receiver idles less than the sender.
		tx_idle_pct = 71;
		rx_idle_pct = 37;
		random_phase(70);
		wait_drained();

		// No idling, with one long receiver hold-off while requests keep coming.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req = 400;
		random_phase(70);

		wait_drained();
		repeat (TABLE_SIZE + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
